@@ hdl/crystal_hit_time_window_merge_macros.svh @@
// assertion helpers for the checker
`ifndef CRYSTAL_HIT_TIME_WINDOW_MERGE_MACROS_SVH
`define CRYSTAL_HIT_TIME_WINDOW_MERGE_MACROS_SVH

// property checked at every rising clock edge outside reset
`define CHTWM_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chtwm check failed");

// signal holds while a request is stalled
`define CHTWM_HOLD(lbl, vld, stl, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> $stable(sig)) else $error("chtwm stalled payload moved");

`endif

@@ hdl/chtwm_pkg.sv @@
`default_nettype none
package chtwm_pkg;

  localparam int unsigned CrystalW = 11;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned EnergyW  = 16;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned CountSat  = 127;

  typedef struct packed {
    logic [CrystalW-1:0] crystal;
    logic [TimeW-1:0]    time_v;
    logic [EnergyW-1:0]  energy;
    logic [EnergyW-1:0]  error_v;
  } hit_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT0,
    ST_KEYRD,
    ST_KEY,
    ST_CMPRD,
    ST_CMP,
    ST_PUT,
    ST_MRD,
    ST_MCHK,
    ST_MACC,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic hit_before(hit_t a, hit_t b);
    logic r;
    if (a.crystal != b.crystal) begin
      r = a.crystal < b.crystal;
    end else begin
      r = a.time_v < b.time_v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/chtwm_store.sv @@
`default_nettype none
module chtwm_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire chtwm_pkg::hit_t  wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output chtwm_pkg::hit_t       rdata_o
);
  chtwm_pkg::hit_t mem_q [Depth];
  chtwm_pkg::hit_t rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hdl/chtwm_div.sv @@
`default_nettype none
module chtwm_div #(
  parameter int unsigned DataW = 38,
  parameter int unsigned DivW  = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DivW-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DataW-1:0]      quotient_o
);
  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DivW:0]    rem_q;
  logic [DataW-1:0] quo_q;
  logic [DivW-1:0]  div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DivW:0]    shifted;
  logic             fits;

  assign shifted = {rem_q[DivW-1:0], quo_q[DataW-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DataW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DataW-2:0], fits};
      rem_q <= fits ? (shifted - {1'b0, div_q}) : shifted;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

@@ hdl/crystal_hit_time_window_merge.sv @@
// load: one hit per cycle, stall is low only while loading
// sort: insertion sort in the store, two or three cycles per key plus two per compare,
//   up to n*(n-1)/2 compares
// merge: three cycles per stored hit, 32+clog2(MAX_HITS+1)+3 cycles per group for the
//   bit-serial dividers, two more for each group after the first, plus any result stall
// reset clears control, fill count and overflow flag; merge_window resets to 16,
//   hit store contents are undefined until written, no clearing pass
`default_nettype none
module crystal_hit_time_window_merge #(
  parameter int unsigned MAX_HITS      = 64,
  parameter int unsigned CRYSTAL_COUNT = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [10:0] crystal_index_i,
  input  wire logic [15:0] hit_time_i,
  input  wire logic [15:0] energy_i,
  input  wire logic [15:0] energy_error_i,
  input  wire logic        last_hit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [10:0]      out_crystal_o,
  output logic [6:0]       hit_count_o,
  output logic [15:0]      mean_time_o,
  output logic [15:0]      mean_energy_o,
  output logic [31:0]      error_term_o,
  output logic             overflow_o,
  output logic             last_result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned TW = 16 + CW;
  localparam int unsigned QW = 32 + CW;

  chtwm_pkg::state_e state_q, state_d;

  logic [15:0]     window_q;
  logic [CW-1:0]   fill_q, i_q, j_q, cnt_q;
  logic            drop_q;
  chtwm_pkg::hit_t key_q, rdata, wdata, in_hit;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CW-1:0]   jm1;
  logic [10:0]     grp_crystal_q;
  logic [15:0]     grp_start_q;
  logic [TW-1:0]   tsum_q, esum_q;
  logic [QW-1:0]   qsum_q;
  logic [31:0]     sq_q;
  logic            accept, in_range, joins, key_first, div_start, div_done;
  logic [2:0]      div_done_v;
  logic [QW-1:0]   tq, eq, qq;
  logic            out_free;

  assign in_hit   = '{crystal: crystal_index_i, time_v: hit_time_i,
                      energy: energy_i, error_v: energy_error_i};
  assign accept   = in_valid_i && (state_q == chtwm_pkg::ST_LOAD);
  assign in_range = 32'(crystal_index_i) < CRYSTAL_COUNT;
  assign jm1      = j_q - CW'(1);
  assign key_first = chtwm_pkg::hit_before(key_q, rdata);
  assign joins    = (cnt_q == '0) || ((rdata.crystal == grp_crystal_q) &&
                    ((rdata.time_v - grp_start_q) <= window_q));
  assign out_free = !out_valid_o || !out_stall_i;
  assign div_done = &div_done_v;

  assign in_stall_o  = state_q != chtwm_pkg::ST_LOAD;
  assign cfg_ready_o = 1'b1;

  chtwm_store #(.Depth(MAX_HITS), .AddrW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  chtwm_div #(.DataW(QW), .DivW(CW)) u_div_t (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(QW'(tsum_q)),
    .divisor_i(cnt_q), .done_o(div_done_v[0]), .quotient_o(tq)
  );
  chtwm_div #(.DataW(QW), .DivW(CW)) u_div_e (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(QW'(esum_q)),
    .divisor_i(cnt_q), .done_o(div_done_v[1]), .quotient_o(eq)
  );
  chtwm_div #(.DataW(QW), .DivW(CW)) u_div_q (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(qsum_q),
    .divisor_i(cnt_q), .done_o(div_done_v[2]), .quotient_o(qq)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chtwm_pkg::ST_LOAD:  if (accept && last_hit_i) state_d = chtwm_pkg::ST_SORT0;
      chtwm_pkg::ST_SORT0: begin
        if (fill_q == '0) state_d = chtwm_pkg::ST_LOAD;
        else if (fill_q == CW'(1)) state_d = chtwm_pkg::ST_MRD;
        else state_d = chtwm_pkg::ST_KEYRD;
      end
      chtwm_pkg::ST_KEYRD: state_d = chtwm_pkg::ST_KEY;
      chtwm_pkg::ST_KEY:   state_d = chtwm_pkg::ST_CMPRD;
      chtwm_pkg::ST_CMPRD: state_d = chtwm_pkg::ST_CMP;
      chtwm_pkg::ST_CMP: begin
        if (key_first) begin
          state_d = (j_q == CW'(1)) ? chtwm_pkg::ST_PUT : chtwm_pkg::ST_CMPRD;
        end else begin
          state_d = (i_q + CW'(1) == fill_q) ? chtwm_pkg::ST_MRD : chtwm_pkg::ST_KEYRD;
        end
      end
      chtwm_pkg::ST_PUT:
        state_d = (i_q + CW'(1) == fill_q) ? chtwm_pkg::ST_MRD : chtwm_pkg::ST_KEYRD;
      chtwm_pkg::ST_MRD:   state_d = chtwm_pkg::ST_MCHK;
      chtwm_pkg::ST_MCHK:  state_d = joins ? chtwm_pkg::ST_MACC : chtwm_pkg::ST_DIVGO;
      chtwm_pkg::ST_MACC:  state_d = (i_q == fill_q) ? chtwm_pkg::ST_DIVGO : chtwm_pkg::ST_MRD;
      chtwm_pkg::ST_DIVGO: state_d = chtwm_pkg::ST_DIV;
      chtwm_pkg::ST_DIV:   if (div_done) state_d = chtwm_pkg::ST_EMIT;
      chtwm_pkg::ST_EMIT: begin
        if (out_free) state_d = (i_q == fill_q) ? chtwm_pkg::ST_LOAD : chtwm_pkg::ST_MRD;
      end
      default: state_d = chtwm_pkg::ST_LOAD;
    endcase
  end

  // memory port and divider control
  always_comb begin
    we        = 1'b0;
    waddr     = fill_q[AW-1:0];
    wdata     = in_hit;
    raddr     = i_q[AW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      chtwm_pkg::ST_LOAD: we = accept && in_range && (fill_q < CW'(MAX_HITS));
      chtwm_pkg::ST_CMPRD: raddr = jm1[AW-1:0];
      chtwm_pkg::ST_CMP: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
        wdata = key_first ? rdata : key_q;
      end
      chtwm_pkg::ST_PUT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = key_q;
      end
      chtwm_pkg::ST_DIVGO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chtwm_pkg::ST_LOAD;
      window_q    <= 16'd16;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) window_q <= cfg_data_i;
      if (state_q == chtwm_pkg::ST_EMIT && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        chtwm_pkg::ST_LOAD: begin
          if (accept && in_range) begin
            if (fill_q < CW'(MAX_HITS)) fill_q <= fill_q + CW'(1);
            else drop_q <= 1'b1;
          end
        end
        chtwm_pkg::ST_SORT0: begin
          i_q   <= (fill_q > CW'(1)) ? CW'(1) : '0;
          cnt_q <= '0;
          if (fill_q == '0) drop_q <= 1'b0;
        end
        chtwm_pkg::ST_KEY: j_q <= i_q;
        chtwm_pkg::ST_CMP: begin
          if (key_first) j_q <= jm1;
          else i_q <= (i_q + CW'(1) == fill_q) ? '0 : i_q + CW'(1);
        end
        chtwm_pkg::ST_PUT: i_q <= (i_q + CW'(1) == fill_q) ? '0 : i_q + CW'(1);
        chtwm_pkg::ST_MCHK: begin
          if (joins) begin
            cnt_q <= cnt_q + CW'(1);
            i_q   <= i_q + CW'(1);
          end
        end
        chtwm_pkg::ST_EMIT: begin
          if (out_free) begin
            cnt_q <= '0;
            if (i_q == fill_q) begin
              fill_q <= '0;
              drop_q <= 1'b0;
              i_q    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == chtwm_pkg::ST_KEY) key_q <= rdata;
    if (state_q == chtwm_pkg::ST_MCHK && joins) begin
      if (cnt_q == '0) begin
        grp_crystal_q <= rdata.crystal;
        grp_start_q   <= rdata.time_v;
        tsum_q        <= TW'(rdata.time_v);
        esum_q        <= TW'(rdata.energy);
        qsum_q        <= '0;
      end else begin
        tsum_q <= tsum_q + TW'(rdata.time_v);
        esum_q <= esum_q + TW'(rdata.energy);
      end
      sq_q <= rdata.error_v * rdata.error_v;
    end
    if (state_q == chtwm_pkg::ST_MACC) qsum_q <= qsum_q + QW'(sq_q);
    if (state_q == chtwm_pkg::ST_EMIT && out_free) begin
      out_crystal_o <= grp_crystal_q;
      hit_count_o   <= (32'(cnt_q) > chtwm_pkg::CountSat) ? 7'(chtwm_pkg::CountSat)
                                                          : 7'(cnt_q);
      mean_time_o   <= tq[15:0];
      mean_energy_o <= eq[15:0];
      error_term_o  <= qq[31:0];
      overflow_o    <= drop_q;
      last_result_o <= i_q == fill_q;
    end
  end
endmodule
`default_nettype wire

@@ hdl/chtwm_checker.sv @@
`default_nettype none
`include "crystal_hit_time_window_merge_macros.svh"
module chtwm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [10:0] crystal_index_i,
  input wire logic [15:0] hit_time_i,
  input wire logic [15:0] energy_i,
  input wire logic [15:0] energy_error_i,
  input wire logic        last_hit_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [10:0] out_crystal_o,
  input wire logic [6:0]  hit_count_o,
  input wire logic [15:0] mean_time_o,
  input wire logic [15:0] mean_energy_o,
  input wire logic [31:0] error_term_o,
  input wire logic        overflow_o,
  input wire logic        last_result_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [15:0] cfg_data_i
);
  // a closing hit starts sort and merge, so loading stops
  `CHTWM_CHECK(a_close_stalls, (in_valid_i && !in_stall_o && last_hit_i) |=> in_stall_o)
  // every merged group holds at least one hit
  `CHTWM_CHECK(a_count_nonzero, out_valid_o |-> (hit_count_o != 7'd0))
  // a result never appears while hits are still being loaded into a fresh slot
  `CHTWM_CHECK(a_new_result_busy, (out_valid_o && !$past(out_valid_o)) |-> $past(in_stall_o))
  `CHTWM_HOLD(a_out_hold, out_valid_o, out_stall_i, mean_time_o)
endmodule

bind crystal_hit_time_window_merge chtwm_checker u_chk (.*);
`default_nettype wire

@@ verif/tb_crystal_hit_time_window_merge.sv @@
module tb_crystal_hit_time_window_merge;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned IdleLimit  = 60000;
  localparam int unsigned DrainWait  = 120;

  typedef struct {
    logic [10:0] crystal;
    logic [6:0]  count;
    logic [15:0] mean_t;
    logic [15:0] mean_e;
    logic [31:0] err_term;
    logic        ovf;
    logic        last;
  } merged_hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [10:0] crystal_index_i = '0;
  logic [15:0] hit_time_i = '0;
  logic [15:0] energy_i = '0;
  logic [15:0] energy_error_i = '0;
  logic        last_hit_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [10:0] out_crystal_o;
  logic [6:0]  hit_count_o;
  logic [15:0] mean_time_o;
  logic [15:0] mean_energy_o;
  logic [31:0] error_term_o;
  logic        overflow_o;
  logic        last_result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  crystal_hit_time_window_merge u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .crystal_index_i, .hit_time_i,
    .energy_i, .energy_error_i, .last_hit_i, .out_valid_o, .out_stall_i,
    .out_crystal_o, .hit_count_o, .mean_time_o, .mean_energy_o, .error_term_o,
    .overflow_o, .last_result_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  chtwm_pkg::hit_t event_hits[$];
  logic        event_dropped = 1'b0;
  logic [15:0] window_model = 16'd16;
  merged_hit_t merged_q[$];

  int unsigned errors = 0;
  int unsigned hits_sent = 0;
  int unsigned results_seen = 0;
  int unsigned events_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          steady = 1'b0;
  bit          rx_steady = 1'b0;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp, results_seen);
    errors++;
  endtask

  // close the event: order by crystal then time, merge within the window
  function automatic void merge_event();
    chtwm_pkg::hit_t srt[$];
    chtwm_pkg::hit_t key;
    int j;
    int i;
    int unsigned cnt;
    longint unsigned tsum, esum, qsum;
    logic [10:0] grp_crystal;
    logic [15:0] first_t;
    merged_hit_t r;
    srt = event_hits;
    for (int k = 1; k < srt.size(); k++) begin
      key = srt[k];
      j = k;
      while (j > 0 && ((key.crystal < srt[j-1].crystal) ||
             (key.crystal == srt[j-1].crystal && key.time_v < srt[j-1].time_v))) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    i = 0;
    while (i < srt.size()) begin
      grp_crystal = srt[i].crystal;
      first_t = srt[i].time_v;
      cnt = 0; tsum = 0; esum = 0; qsum = 0;
      while (i < srt.size() && srt[i].crystal == grp_crystal &&
             (srt[i].time_v - first_t) <= window_model) begin
        tsum += srt[i].time_v;
        esum += srt[i].energy;
        qsum += longint'(srt[i].error_v) * longint'(srt[i].error_v);
        cnt++;
        i++;
      end
      r.crystal = grp_crystal;
      r.count = (cnt > chtwm_pkg::CountSat) ? 7'(chtwm_pkg::CountSat) : 7'(cnt);
      r.mean_t = 16'(tsum / cnt);
      r.mean_e = 16'(esum / cnt);
      r.err_term = 32'(qsum / cnt);
      r.ovf = event_dropped;
      r.last = (i >= srt.size());
      merged_q = {merged_q, r};
    end
    event_hits.delete();
    event_dropped = 1'b0;
  endfunction

  // accepted requests on every channel, sampled at the rising edge
  always @(posedge clk_i) begin
    chtwm_pkg::hit_t h;
    merged_hit_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (crystal_index_i < 2048) begin
          if (event_hits.size() < StoreDepth) begin
            h.crystal = crystal_index_i;
            h.time_v = hit_time_i;
            h.energy = energy_i;
            h.error_v = energy_error_i;
            event_hits = {event_hits, h};
          end else begin
            event_dropped = 1'b1;
          end
        end
        if (last_hit_i) merge_event();
      end
      if (cfg_valid_i && cfg_ready_o) window_model = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (merged_q.size() == 0) begin
          $display("unexpected result for crystal %0d", out_crystal_o);
          errors++;
        end else begin
          e = merged_q.pop_front();
          if (out_crystal_o !== e.crystal) report_mismatch("crystal", out_crystal_o, e.crystal);
          if (hit_count_o !== e.count) report_mismatch("hit_count", hit_count_o, e.count);
          if (mean_time_o !== e.mean_t) report_mismatch("mean_time", mean_time_o, e.mean_t);
          if (mean_energy_o !== e.mean_e)
            report_mismatch("mean_energy", mean_energy_o, e.mean_e);
          if (error_term_o !== e.err_term)
            report_mismatch("error_term", error_term_o, e.err_term);
          if (overflow_o !== e.ovf) report_mismatch("overflow", overflow_o, e.ovf);
          if (last_result_o !== e.last) report_mismatch("last_result", last_result_o, e.last);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("timeout: no request moved for %0d cycles", IdleLimit);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_steady <= ~rx_steady;
      if (rx_steady) begin
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: out_stall_i <= 1'b1;
          1, 2, 3, 4, 5: out_stall_i <= ~out_stall_i;
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_hit(logic [10:0] cr, logic [15:0] t, logic [15:0] en,
                          logic [15:0] er, logic last);
    int unsigned gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    crystal_index_i = cr;
    hit_time_i = t;
    energy_i = en;
    energy_error_i = er;
    last_hit_i = last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    hits_sent++;
    if (last) events_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (merged_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_window(logic [15:0] w);
    wait_drained();
    repeat (DrainWait) @(negedge clk_i);
    cfg_data_i = w;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // clustered event: few crystals, times near a base so groups form
  task automatic send_event(int unsigned n, int unsigned pool, int unsigned spread);
    logic [10:0] base_c;
    logic [15:0] base_t;
    base_c = 11'($urandom_range(0, 2047));
    base_t = 16'($urandom);
    steady = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_hit(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), k == n - 1);
      else
        send_hit(base_c + 11'($urandom_range(0, pool - 1)),
                 base_t + 16'($urandom_range(0, spread)),
                 16'($urandom), 16'($urandom), k == n - 1);
    end
  endtask

  task automatic test_directed();
    send_hit(11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_hit(11'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    // unsorted crystals, window edge at 16 and 17 above the first hit
    send_hit(11'd5, 16'd117, 16'd30, 16'd3, 1'b0);
    send_hit(11'd5, 16'd100, 16'd10, 16'd1, 1'b0);
    send_hit(11'd2, 16'd500, 16'd7, 16'd9, 1'b0);
    send_hit(11'd5, 16'd116, 16'd21, 16'd2, 1'b0);
    send_hit(11'd2, 16'd500, 16'd8, 16'd9, 1'b0);
    send_hit(11'd5, 16'd133, 16'd40, 16'd4, 1'b1);
    // equal times with big errors, truncated means
    send_hit(11'd1024, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0);
    send_hit(11'd1024, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
    send_hit(11'd1024, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
    send_hit(11'd1023, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_hit(11'd682, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_window_extremes();
    write_window(16'd0);
    send_hit(11'd9, 16'd40, 16'd1, 16'd1, 1'b0);
    send_hit(11'd9, 16'd40, 16'd2, 16'd2, 1'b0);
    send_hit(11'd9, 16'd41, 16'd3, 16'd3, 1'b1);
    write_window(16'hFFFF);
    send_hit(11'd9, 16'd0, 16'd1, 16'd1, 1'b0);
    send_hit(11'd9, 16'hFFFF, 16'd2, 16'd2, 1'b0);
    send_hit(11'd10, 16'd7, 16'd3, 16'd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    write_window(16'd16);
    for (int unsigned k = 0; k < 66; k++)
      send_hit(11'($urandom_range(300, 303)), 16'($urandom_range(0, 60)),
               16'($urandom), 16'($urandom), 1'b0);
    // last hit is dropped but still closes the event
    send_hit(11'd301, 16'd3, 16'd3, 16'd3, 1'b1);
    // one crystal, one group of the full store
    write_window(16'hFFFF);
    for (int unsigned k = 0; k < StoreDepth; k++)
      send_hit(11'd77, 16'($urandom), 16'($urandom), 16'($urandom), k == StoreDepth - 1);
    send_event(3, 2, 40);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_window(16'd24);
    hold_left = 2000;
    send_event(20, 3, 60);
    send_event(12, 2, 60);
    send_event(5, 1, 30);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sz;
    while (hits_sent < 460) begin
      if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 3))
          0: write_window(16'd0);
          1: write_window(16'hFFFF);
          default: write_window(16'($urandom_range(1, 200)));
        endcase
      end
      sz = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      send_event(sz, $urandom_range(1, 4), $urandom_range(0, 1) ? 300 : 65535);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_window_extremes();
    test_store_full();
    test_backpressure();
    test_random();
    repeat (DrainWait) @(posedge clk_i);
    $display("sent %0d hits in %0d events, checked %0d merged hits", hits_sent,
             events_sent, results_seen);
    $display("windows 0, 16, 24, 65535 and random, store overflow and long output hold-off");
    if (errors == 0 && merged_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, merged_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
